FILE: src/sos_pkg.sv
// Shared types and constants for the side overlap spotter.
// No dependencies; used by sos_geom and side_overlap_spotter_top.
package sos_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_OPP   = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  // Callout codes on the result channel
  typedef enum logic [1:0] {
    CALL_NONE  = 2'd0,
    CALL_THREE = 2'd1,
    CALL_LEFT  = 2'd2,
    CALL_RIGHT = 2'd3
  } call_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ENGAGE_TIME   = 3'd0,
    CFG_CLEAR_HOLD    = 3'd1,
    CFG_REPEAT_COOL   = 3'd2,
    CFG_CALL_INTERVAL = 3'd3,
    CFG_MAX_DIST_SQ   = 3'd4,
    CFG_MIN_SPEED     = 3'd5,
    CFG_ENGAGE_LONG   = 3'd6,
    CFG_CLEAR_LONG    = 3'd7
  } cfg_idx_t;

  // Configuration reset values
  localparam logic [15:0] RST_ENGAGE_TIME   = 16'd180;
  localparam logic [15:0] RST_CLEAR_HOLD    = 16'd1500;
  localparam logic [15:0] RST_REPEAT_COOL   = 16'd8000;
  localparam logic [15:0] RST_CALL_INTERVAL = 16'd2500;
  localparam logic [31:0] RST_MAX_DIST_SQ   = 32'd4000000;
  localparam logic [11:0] RST_MIN_SPEED     = 12'd150;
  localparam logic [11:0] RST_ENGAGE_LONG   = 12'd400;
  localparam logic [11:0] RST_CLEAR_LONG    = 12'd540;

  // Rotated coordinates are Q14 cm
  localparam int ROT_W = 34;
  localparam int Q14 = 14;
  localparam int NEAR_LIMIT = 65535;

  localparam logic [ROT_W-1:0] ENG_LAT_MIN = ROT_W'(100 << Q14);
  localparam logic [ROT_W-1:0] ENG_LAT_MAX = ROT_W'(380 << Q14);
  localparam logic [ROT_W-1:0] CLR_LAT_MIN = ROT_W'(60 << Q14);
  localparam logic [ROT_W-1:0] CLR_LAT_MAX = ROT_W'(460 << Q14);

  // Side timer slots
  localparam int T_LACT = 0;
  localparam int T_RACT = 1;
  localparam int T_LCLR = 2;
  localparam int T_RCLR = 3;

  // Callout time slots
  localparam int C_ANY   = 0;
  localparam int C_LEFT  = 1;
  localparam int C_RIGHT = 2;
  localparam int C_THREE = 3;

  // Geometry of one opponent in the player frame
  typedef struct packed {
    logic [ROT_W-1:0] alon;
    logic [ROT_W-1:0] alat;
    logic             lat_neg;
    logic             lat_pos;
    logic             near;
  } geo_t;

endpackage

FILE: src/side_overlap_spotter_top.sv
// Side overlap spotter top level: input register, control pipeline, side state, callouts.
// Depends on sos_pkg and sos_geom.
//
// Usage: a frame is a start item (pose, link, speed), any number of opponent
// items and an end item carrying now_ms. Items enter on in_valid/in_stall and
// one transfer is taken every cycle while in_stall is low. An end item of an
// active frame that saw an opponent, or with a side engaged, yields one result
// (callout, left_busy, right_busy) on out_valid/out_stall; other items yield none.
// Path: the result register is loaded by the side state update after the end
// item has passed the input register, offset, products, sums and range/abs
// stages. Throughput is one item per cycle while in_stall is low, set by the
// single pass of the geometry pipeline in sos_geom.
// Output stall: the result register holds; items keep flowing until an end
// item reaches the state stage while a result still waits, then in_stall
// rises until the result is taken.
// Configuration: cfg_valid/cfg_ready writes by index, always ready; write only
// while idle. Reset (rst, synchronous) restores register defaults, clears the
// side state and the frame, and empties the pipeline.
module side_overlap_spotter_top #(
  parameter int POS_WIDTH  = 24,
  parameter int TIME_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  // item input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  kind,
  input  logic signed [POS_WIDTH-1:0] pos_x,
  input  logic signed [POS_WIDTH-1:0] pos_z,
  input  logic signed [15:0]          heading_cos,
  input  logic signed [15:0]          heading_sin,
  input  logic [11:0]                 speed_tenths,
  input  logic                        speed_present,
  input  logic                        point_valid,
  input  logic                        connected,
  input  logic [TIME_WIDTH-1:0]       now_ms,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  callout,
  output logic                        left_busy,
  output logic                        right_busy
);
  import sos_pkg::*;

  localparam int STAGES = 5;

  typedef struct packed {
    logic [1:0]            kind;
    logic                  point_valid;
    logic                  connected;
    logic                  speed_present;
    logic [11:0]           speed_tenths;
    logic [TIME_WIDTH-1:0] now_ms;
  } ctrl_t;

  // configuration registers
  logic [15:0] engage_time_ms;
  logic [15:0] clear_hold_ms;
  logic [15:0] repeat_cooldown_ms;
  logic [15:0] callout_interval_ms;
  logic [31:0] max_distance_sq;
  logic [11:0] min_speed_tenths;
  logic [11:0] engage_long_cm;
  logic [11:0] clear_long_cm;

  // pipeline
  logic                        adv;
  logic [STAGES-1:0]           vld;
  ctrl_t                       ctrl [STAGES];
  logic signed [POS_WIDTH-1:0] a_pos_x;
  logic signed [POS_WIDTH-1:0] a_pos_z;
  logic signed [15:0]          a_cos;
  logic signed [15:0]          a_sin;
  geo_t                        geo;
  ctrl_t                       g;

  // side and frame state
  logic                  left_eng, right_eng;
  logic [3:0]            tmr_vld;
  logic [TIME_WIDTH-1:0] tmr [4];
  logic [3:0]            call_vld;
  logic [TIME_WIDTH-1:0] call_tm [4];
  logic                  frm_active, frm_any, frm_left, frm_right;

  logic                  left_eng_next, right_eng_next;
  logic [3:0]            tmr_vld_next;
  logic [TIME_WIDTH-1:0] tmr_next [4];
  logic [3:0]            call_vld_next;
  logic [TIME_WIDTH-1:0] call_tm_next [4];
  logic                  frm_active_next, frm_any_next, frm_left_next, frm_right_next;
  logic                  res_load;
  call_t                 res_code;

  assign cfg_ready = 1'b1;
  assign g = ctrl[STAGES-1];

  // hold when an end item reaches the last stage while a stalled result waits
  assign adv      = !(out_valid && out_stall && vld[STAGES-1] && (g.kind == KIND_END));
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      engage_time_ms      <= RST_ENGAGE_TIME;
      clear_hold_ms       <= RST_CLEAR_HOLD;
      repeat_cooldown_ms  <= RST_REPEAT_COOL;
      callout_interval_ms <= RST_CALL_INTERVAL;
      max_distance_sq     <= RST_MAX_DIST_SQ;
      min_speed_tenths    <= RST_MIN_SPEED;
      engage_long_cm      <= RST_ENGAGE_LONG;
      clear_long_cm       <= RST_CLEAR_LONG;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENGAGE_TIME:   engage_time_ms      <= cfg_data[15:0];
        CFG_CLEAR_HOLD:    clear_hold_ms       <= cfg_data[15:0];
        CFG_REPEAT_COOL:   repeat_cooldown_ms  <= cfg_data[15:0];
        CFG_CALL_INTERVAL: callout_interval_ms <= cfg_data[15:0];
        CFG_MAX_DIST_SQ:   max_distance_sq     <= cfg_data;
        CFG_MIN_SPEED:     min_speed_tenths    <= cfg_data[11:0];
        CFG_ENGAGE_LONG:   engage_long_cm      <= cfg_data[11:0];
        CFG_CLEAR_LONG:    clear_long_cm       <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // input register and control shadow of the geometry stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl[0] <= '{kind: kind, point_valid: point_valid, connected: connected,
                   speed_present: speed_present, speed_tenths: speed_tenths,
                   now_ms: now_ms};
      for (int i = 1; i < STAGES; i++) begin
        ctrl[i] <= ctrl[i-1];
      end
      a_pos_x <= pos_x;
      a_pos_z <= pos_z;
      a_cos   <= heading_cos;
      a_sin   <= heading_sin;
    end
  end

  sos_geom #(
    .POS_WIDTH(POS_WIDTH)
  ) u_geom (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .pose_load      (adv && vld[0] && (ctrl[0].kind == KIND_START)),
    .pos_x          (a_pos_x),
    .pos_z          (a_pos_z),
    .heading_cos    (a_cos),
    .heading_sin    (a_sin),
    .max_distance_sq(max_distance_sq),
    .geo            (geo)
  );

  // side state update for the item leaving the pipeline
  always_comb begin
    logic                  slow;
    logic                  eng_sel;
    logic [ROT_W-1:0]      llim;
    logic [ROT_W-1:0]      lmin;
    logic [ROT_W-1:0]      lmax;
    logic                  along;
    logic [1:0]            act;
    logic [1:0]            eng_old;
    logic [1:0]            eng_new;
    logic [15:0]           dur_on;
    logic [15:0]           dur_off;
    logic                  cadence;
    logic [TIME_WIDTH-1:0] now;

    left_eng_next   = left_eng;
    right_eng_next  = right_eng;
    tmr_vld_next    = tmr_vld;
    tmr_next        = tmr;
    call_vld_next   = call_vld;
    call_tm_next    = call_tm;
    frm_active_next = frm_active;
    frm_any_next    = frm_any;
    frm_left_next   = frm_left;
    frm_right_next  = frm_right;
    res_load        = 1'b0;
    res_code        = CALL_NONE;

    now     = g.now_ms;
    slow    = g.speed_present && (g.speed_tenths < min_speed_tenths) && !left_eng && !right_eng;
    eng_sel = geo.lat_neg ? left_eng : right_eng;
    llim    = ROT_W'({(eng_sel ? clear_long_cm : engage_long_cm), Q14'(0)});
    lmin    = eng_sel ? CLR_LAT_MIN : ENG_LAT_MIN;
    lmax    = eng_sel ? CLR_LAT_MAX : ENG_LAT_MAX;
    along   = (geo.alon <= llim) && (geo.alat >= lmin) && (geo.alat <= lmax);
    act     = {frm_right, frm_left};
    eng_old = {right_eng, left_eng};
    eng_new = eng_old;
    dur_on  = engage_time_ms;
    dur_off = clear_hold_ms;
    cadence = !call_vld[C_ANY] ||
              ((now - call_tm[C_ANY]) >= TIME_WIDTH'(callout_interval_ms));

    if (adv && vld[STAGES-1]) begin
      case (g.kind)
        KIND_START: begin
          frm_any_next    = 1'b0;
          frm_left_next   = 1'b0;
          frm_right_next  = 1'b0;
          frm_active_next = 1'b0;
          if (!g.connected) begin
            // link lost: drop all side and callout history
            left_eng_next  = 1'b0;
            right_eng_next = 1'b0;
            tmr_vld_next   = '0;
            call_vld_next  = '0;
          end else if (g.point_valid && !slow) begin
            frm_active_next = 1'b1;
          end
        end
        KIND_OPP: begin
          if (frm_active) begin
            frm_any_next = 1'b1;
            if (g.point_valid && geo.near && along) begin
              if (geo.lat_neg) begin
                frm_left_next = 1'b1;
              end else if (geo.lat_pos) begin
                frm_right_next = 1'b1;
              end
            end
          end
        end
        KIND_END: begin
          if (frm_active) begin
            frm_active_next = 1'b0;
            frm_any_next    = 1'b0;
            frm_left_next   = 1'b0;
            frm_right_next  = 1'b0;
            if (frm_any || left_eng || right_eng) begin
              res_load = 1'b1;
              // side 0 is left (slots T_LACT, T_LCLR), side 1 right
              for (int s = 0; s < 2; s++) begin
                if (act[s]) begin
                  tmr_vld_next[s+2] = 1'b0;
                  if (!eng_old[s] && !tmr_vld[s]) begin
                    tmr_vld_next[s] = 1'b1;
                    tmr_next[s]     = now;
                  end
                end else begin
                  tmr_vld_next[s] = 1'b0;
                  if (eng_old[s] && !tmr_vld[s+2]) begin
                    tmr_vld_next[s+2] = 1'b1;
                    tmr_next[s+2]     = now;
                  end
                end
                if (!eng_old[s] && tmr_vld_next[s] &&
                    ((now - tmr_next[s]) >= TIME_WIDTH'(dur_on))) begin
                  tmr_vld_next[s] = 1'b0;
                  eng_new[s]      = 1'b1;
                end else if (eng_old[s] && tmr_vld_next[s+2] &&
                    ((now - tmr_next[s+2]) >= TIME_WIDTH'(dur_off))) begin
                  tmr_vld_next[s+2] = 1'b0;
                  eng_new[s]        = 1'b0;
                end
              end
              left_eng_next  = eng_new[0];
              right_eng_next = eng_new[1];

              if (eng_new[0] && eng_new[1] && (!eng_old[0] || !eng_old[1]) &&
                  (!call_vld[C_THREE] ||
                   ((now - call_tm[C_THREE]) >= TIME_WIDTH'(repeat_cooldown_ms)))) begin
                res_code               = CALL_THREE;
                call_vld_next[C_THREE] = 1'b1;
                call_tm_next[C_THREE]  = now;
                call_vld_next[C_ANY]   = 1'b1;
                call_tm_next[C_ANY]    = now;
              end else if (eng_new[0] && !eng_new[1] && !eng_old[0] && cadence &&
                  (!call_vld[C_LEFT] ||
                   ((now - call_tm[C_LEFT]) >= TIME_WIDTH'(repeat_cooldown_ms)))) begin
                res_code              = CALL_LEFT;
                call_vld_next[C_LEFT] = 1'b1;
                call_tm_next[C_LEFT]  = now;
                call_vld_next[C_ANY]  = 1'b1;
                call_tm_next[C_ANY]   = now;
              end else if (!eng_new[0] && eng_new[1] && !eng_old[1] && cadence &&
                  (!call_vld[C_RIGHT] ||
                   ((now - call_tm[C_RIGHT]) >= TIME_WIDTH'(repeat_cooldown_ms)))) begin
                res_code               = CALL_RIGHT;
                call_vld_next[C_RIGHT] = 1'b1;
                call_tm_next[C_RIGHT]  = now;
                call_vld_next[C_ANY]   = 1'b1;
                call_tm_next[C_ANY]    = now;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_eng   <= 1'b0;
      right_eng  <= 1'b0;
      tmr_vld    <= '0;
      call_vld   <= '0;
      frm_active <= 1'b0;
      frm_any    <= 1'b0;
      frm_left   <= 1'b0;
      frm_right  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      left_eng   <= left_eng_next;
      right_eng  <= right_eng_next;
      tmr_vld    <= tmr_vld_next;
      call_vld   <= call_vld_next;
      frm_active <= frm_active_next;
      frm_any    <= frm_any_next;
      frm_left   <= frm_left_next;
      frm_right  <= frm_right_next;
      out_valid  <= res_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    tmr     <= tmr_next;
    call_tm <= call_tm_next;
    if (res_load) begin
      callout    <= res_code;
      left_busy  <= left_eng_next;
      right_busy <= right_eng_next;
    end
  end

  // a hold only ever comes from a waiting, stalled result
  assert property (@(posedge clk) disable iff (rst)
    !adv |-> (out_valid && out_stall))
    else $error("pipeline held without a stalled result");

  // a fresh result reports the side state it was computed with
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (left_busy == left_eng) && (right_busy == right_eng))
    else $error("result busy flags differ from side state");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (callout == CALL_THREE)) |-> (left_busy && right_busy))
    else $error("three wide callout without both sides busy");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((callout == CALL_LEFT) || (callout == CALL_RIGHT))) |->
      (left_busy != right_busy))
    else $error("single side callout with both or no sides busy");

  // a side is never timing engage and clear at once
  assert property (@(posedge clk) disable iff (rst)
    !(tmr_vld[T_LACT] && tmr_vld[T_LCLR]) && !(tmr_vld[T_RACT] && tmr_vld[T_RCLR]))
    else $error("side timing both engage and clear");

  assert property (@(posedge clk) disable iff (rst)
    (frm_any || frm_left || frm_right) |-> frm_active)
    else $error("frame flags set outside an active frame");

endmodule

FILE: src/sos_geom.sv
// Opponent geometry pipeline: offset, rotation into the player frame, range check.
// Depends on sos_pkg. Four register stages, all advanced by adv.
module sos_geom #(
  parameter int POS_WIDTH = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        pose_load,
  input  logic signed [POS_WIDTH-1:0] pos_x,
  input  logic signed [POS_WIDTH-1:0] pos_z,
  input  logic signed [15:0]          heading_cos,
  input  logic signed [15:0]          heading_sin,
  input  logic [31:0]                 max_distance_sq,
  output sos_pkg::geo_t               geo
);
  import sos_pkg::*;

  localparam int DW = POS_WIDTH + 1;
  localparam logic signed [DW-1:0] FAR_POS = DW'(NEAR_LIMIT);
  localparam logic signed [DW-1:0] FAR_NEG = -FAR_POS;

  // player pose
  logic signed [POS_WIDTH-1:0] px;
  logic signed [POS_WIDTH-1:0] pz;
  logic signed [15:0]          pc;
  logic signed [15:0]          ps;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dz;
  logic        [DW-1:0] adx;
  logic        [DW-1:0] adz;
  logic                 far;

  // offset stage
  logic signed [16:0] b_dx;
  logic signed [16:0] b_dz;
  logic [15:0]        b_ax;
  logic [15:0]        b_az;
  logic               b_far;
  logic signed [15:0] b_cos;
  logic signed [15:0] b_sin;

  // product stage
  logic signed [32:0] c_xc;
  logic signed [32:0] c_zs;
  logic signed [32:0] c_xs;
  logic signed [32:0] c_zc;
  logic [31:0]        c_sqx;
  logic [31:0]        c_sqz;
  logic               c_far;

  // sum stage
  logic signed [ROT_W-1:0] d_lon;
  logic signed [ROT_W-1:0] d_lat;
  logic [32:0]             d_dist;
  logic                    d_far;

  always_comb begin
    dx  = $signed({pos_x[POS_WIDTH-1], pos_x}) - $signed({px[POS_WIDTH-1], px});
    dz  = $signed({pos_z[POS_WIDTH-1], pos_z}) - $signed({pz[POS_WIDTH-1], pz});
    adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    adz = dz[DW-1] ? DW'(-dz) : DW'(dz);
    far = (dx > FAR_POS) || (dx < FAR_NEG) || (dz > FAR_POS) || (dz < FAR_NEG);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0;
      pz <= '0;
      pc <= '0;
      ps <= '0;
    end else if (pose_load) begin
      px <= pos_x;
      pz <= pos_z;
      pc <= heading_cos;
      ps <= heading_sin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_dx  <= dx[16:0];
      b_dz  <= dz[16:0];
      b_ax  <= adx[15:0];
      b_az  <= adz[15:0];
      b_far <= far;
      b_cos <= pc;
      b_sin <= ps;

      c_xc  <= b_dx * b_cos;
      c_zs  <= b_dz * b_sin;
      c_xs  <= b_dx * b_sin;
      c_zc  <= b_dz * b_cos;
      c_sqx <= b_ax * b_ax;
      c_sqz <= b_az * b_az;
      c_far <= b_far;

      d_lon  <= ROT_W'(c_xc) - ROT_W'(c_zs);
      d_lat  <= ROT_W'(c_xs) + ROT_W'(c_zc);
      d_dist <= {1'b0, c_sqx} + {1'b0, c_sqz};
      d_far  <= c_far;

      geo.alon    <= d_lon[ROT_W-1] ? ROT_W'(-d_lon) : ROT_W'(d_lon);
      geo.alat    <= d_lat[ROT_W-1] ? ROT_W'(-d_lat) : ROT_W'(d_lat);
      geo.lat_neg <= d_lat[ROT_W-1];
      geo.lat_pos <= !d_lat[ROT_W-1] && (d_lat != '0);
      geo.near    <= !d_far && (d_dist <= {1'b0, max_distance_sq});
    end
  end

endmodule
